>>> hw/rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative cache lookup: field
// widths, configuration register indexes and the result of the way compare.
// ----------------------------------------------------------------------------
package sacl_pkg;

	// Widths of the counters, stamps and the address field.
	localparam int CNT_W       = 32;
	localparam int STAMP_W     = 32;
	localparam int FIELD_ADDR_W = 48;

	// Widths of the configuration registers and the write port.
	localparam int OFFS_W     = 4;
	localparam int SIDX_W     = 3;
	localparam int WAYC_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	// The set index field before wrapping spans at most seven bits.
	localparam int RAW_SET_W  = 7;
	localparam int RAW_SET_N  = 1 << RAW_SET_W;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LRU    = 2'd3;

	// Result of comparing one way against the current access.
	typedef struct packed {
		logic               match;
		logic               older;
		logic [STAMP_W-1:0] age;
	} cmp_res_t;

endpackage

>>> hw/rtl/set_assoc_cache_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup
// Set-associative cache lookup with write-through, write-allocate and FIFO or
// LRU replacement. Keeps hit, miss, memory read and memory write counts.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    kind, address
//   out      output     out_valid / out_ready  hit, memory_read, memory_write,
//                                              four running counts
//   cfg      input      cfg_we (no wait)       cfg_index, cfg_data
//
// A transaction scans N ways between acceptance and the next acceptance,
// where N is the number of ways compared (up to the first hit, at most the
// ways in use): one shared tag and age compare unit examines one way per
// cycle as the tag and stamp memories deliver it.
// After reset a clearing pass zeroes every row of the valid memory; no
// transaction is accepted meanwhile, configuration writes are taken.
// The update step waits while the output register still holds an untaken
// result.
// ----------------------------------------------------------------------------
module set_assoc_cache_lookup #(
	parameter int SETS      = 64,
	parameter int WAYS      = 8,
	parameter int ADDR_BITS = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Access channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [sacl_pkg::FIELD_ADDR_W-1:0] address,
	// Result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic                              memory_read,
	output logic                              memory_write,
	output logic [sacl_pkg::CNT_W-1:0]        hit_count,
	output logic [sacl_pkg::CNT_W-1:0]        miss_count,
	output logic [sacl_pkg::CNT_W-1:0]        memory_read_count,
	output logic [sacl_pkg::CNT_W-1:0]        memory_write_count,
	// Configuration write port
	input  logic                              cfg_we,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sacl_pkg::*;

	localparam int ADDR_W   = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;
	localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LINE_AW  = SET_W + WAY_W;
	localparam int LINE_N   = 1 << LINE_AW;
	localparam int ROW_N    = 1 << SET_W;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

	// Configuration registers.
	logic [OFFS_W-1:0] offset_bits_q;
	logic [SIDX_W-1:0] set_index_bits_q;
	logic [WAYC_W-1:0] ways_in_use_q;
	logic              replace_lru_q;

	// Sequencer and per-access registers.
	logic [1:0]         state_q;
	logic [SET_W-1:0]   clr_q;
	logic [SET_W-1:0]   set_q;
	logic [ADDR_W-1:0]  tag_q;
	logic               write_q;
	logic [WAY_W-1:0]   idx_q;
	logic               hit_q;
	logic [WAY_W-1:0]   hit_way_q;
	logic               inv_found_q;
	logic [WAY_W-1:0]   inv_way_q;
	logic               have_best_q;
	logic [STAMP_W-1:0] best_age_q;
	logic [WAY_W-1:0]   best_way_q;
	logic [STAMP_W-1:0] clock_q;

	// Counters and output register.
	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] misses_q;
	logic [CNT_W-1:0] reads_q;
	logic [CNT_W-1:0] writes_q;
	logic             out_valid_q;
	logic             res_hit_q;
	logic             res_write_q;

	// Address split signals.
	logic [ADDR_W-1:0]    addr_c;
	logic [ADDR_W-1:0]    above_c;
	logic [ADDR_W-1:0]    tag_c;
	logic [RAW_SET_W-1:0] set_mask_c;
	logic [RAW_SET_W-1:0] raw_set_c;
	logic [SET_W-1:0]     set_c;
	logic [SET_W-1:0]     set_tbl [RAW_SET_N];

	// Way selection and memory signals.
	logic [WAYC_W:0]    ways_sel;
	logic [WAY_W-1:0]   way_last;
	logic               accept;
	logic               load;
	logic               way_valid;
	logic [WAY_W-1:0]   victim;
	logic [WAYS-1:0]    vld_rdata;
	logic [WAYS-1:0]    vld_wdata;
	logic               vld_we;
	logic [SET_W-1:0]   vld_waddr;
	logic [ADDR_W-1:0]  tag_rdata;
	logic [STAMP_W-1:0] stamp_rdata;
	logic               line_re;
	logic [LINE_AW-1:0] line_raddr;
	logic [LINE_AW-1:0] line_waddr;
	logic               tag_we;
	logic               stamp_we;
	cmp_res_t           cmp;

	// Set index wrap as a constant table over every raw index value.
	for (genvar g = 0; g < RAW_SET_N; g++) begin : g_set_tbl
		assign set_tbl[g] = SET_W'(g % SETS);
	end

	// Split the incoming address into set and tag.
	always_comb begin
		addr_c     = address[ADDR_W-1:0];
		above_c    = addr_c >> offset_bits_q;
		tag_c      = above_c >> set_index_bits_q;
		set_mask_c = RAW_SET_W'((8'd1 << set_index_bits_q) - 8'd1);
		raw_set_c  = above_c[RAW_SET_W-1:0] & set_mask_c;
		set_c      = set_tbl[raw_set_c];
	end

	// Ways in use, with zero read as one and anything above WAYS as WAYS.
	always_comb begin
		ways_sel = (ways_in_use_q == '0) ? (WAYC_W+1)'(1) : {1'b0, ways_in_use_q};
		if (ways_sel > (WAYC_W+1)'(WAYS)) begin
			ways_sel = (WAYC_W+1)'(WAYS);
		end
		way_last = WAY_W'(ways_sel - (WAYC_W+1)'(1));
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load     = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q    <= '0;
			set_index_bits_q <= '0;
			ways_in_use_q    <= WAYC_W'(1);
			replace_lru_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OFFSET_BITS:    offset_bits_q    <= cfg_data[OFFS_W-1:0];
				CFG_SET_INDEX_BITS: set_index_bits_q <= cfg_data[SIDX_W-1:0];
				CFG_WAYS_IN_USE:    ways_in_use_q    <= cfg_data[WAYC_W-1:0];
				CFG_REPLACE_LRU:    replace_lru_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Memory addressing: the read runs one way ahead of the compare.
	always_comb begin
		victim     = hit_q ? hit_way_q : (inv_found_q ? inv_way_q : best_way_q);
		line_re    = accept || (state_q == ST_SCAN);
		line_raddr = (state_q == ST_SCAN) ? {set_q, idx_q + WAY_W'(1)} : {set_c, WAY_W'(0)};
		line_waddr = {set_q, victim};
		tag_we     = load && !hit_q;
		stamp_we   = load && (!hit_q || replace_lru_q);
		vld_we     = (state_q == ST_CLEAR) || (load && !hit_q);
		vld_waddr  = (state_q == ST_CLEAR) ? clr_q : set_q;
		vld_wdata  = (state_q == ST_CLEAR) ? '0 : (vld_rdata | (WAYS'(1) << victim));
		way_valid  = vld_rdata[idx_q];
	end

	sacl_ram #(
		.WIDTH (WAYS),
		.DEPTH (ROW_N)
	) u_valid_ram (
		.clk   (clk),
		.we    (vld_we),
		.waddr (vld_waddr),
		.wdata (vld_wdata),
		.re    (accept),
		.raddr (set_c),
		.rdata (vld_rdata)
	);

	sacl_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (LINE_N)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (line_waddr),
		.wdata (tag_q),
		.re    (line_re),
		.raddr (line_raddr),
		.rdata (tag_rdata)
	);

	sacl_ram #(
		.WIDTH (STAMP_W),
		.DEPTH (LINE_N)
	) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (line_waddr),
		.wdata (clock_q),
		.re    (line_re),
		.raddr (line_raddr),
		.rdata (stamp_rdata)
	);

	sacl_way_cmp #(
		.TAG_W (ADDR_W)
	) u_way_cmp (
		.key_tag   (tag_q),
		.way_tag   (tag_rdata),
		.now       (clock_q),
		.way_stamp (stamp_rdata),
		.best_age  (best_age_q),
		.have_best (have_best_q),
		.res       (cmp)
	);

	// Sequencer: clear, wait, scan the ways one per cycle, update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			inv_found_q <= 1'b0;
			have_best_q <= 1'b0;
			clock_q     <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			reads_q     <= '0;
			writes_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SET_W'(1);
					if (clr_q == SET_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						idx_q       <= '0;
						hit_q       <= 1'b0;
						inv_found_q <= 1'b0;
						have_best_q <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (way_valid && cmp.match) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPDATE;
					end else begin
						if (!way_valid && !inv_found_q) begin
							inv_found_q <= 1'b1;
						end
						if (way_valid && cmp.older) begin
							have_best_q <= 1'b1;
						end
						if (idx_q == way_last) begin
							state_q <= ST_UPDATE;
						end else begin
							idx_q <= idx_q + WAY_W'(1);
						end
					end
				end
				ST_UPDATE: begin
					if (load) begin
						if (hit_q) begin
							hits_q <= sat_inc(hits_q);
						end else begin
							misses_q <= sat_inc(misses_q);
							reads_q  <= sat_inc(reads_q);
						end
						if (write_q) begin
							writes_q <= sat_inc(writes_q);
						end
						clock_q <= clock_q + STAMP_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// The output register fills with a new result and empties once
			// the held result is taken.
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the access and of the scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			set_q   <= set_c;
			tag_q   <= tag_c;
			write_q <= kind;
		end
		if (state_q == ST_SCAN) begin
			if (way_valid && cmp.match) begin
				hit_way_q <= idx_q;
			end
			if (!way_valid && !inv_found_q) begin
				inv_way_q <= idx_q;
			end
			if (way_valid && cmp.older) begin
				best_age_q <= cmp.age;
				best_way_q <= idx_q;
			end
		end
		if (load) begin
			res_hit_q   <= hit_q;
			res_write_q <= write_q;
		end
	end

	// The counters change only when a new result is loaded, so they can
	// drive the result ports directly.
	assign out_valid          = out_valid_q;
	assign hit                = res_hit_q;
	assign memory_read        = !res_hit_q;
	assign memory_write       = res_write_q;
	assign hit_count          = hits_q;
	assign miss_count         = misses_q;
	assign memory_read_count  = reads_q;
	assign memory_write_count = writes_q;

`ifndef SYNTHESIS
	// No access is taken while the valid memory is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("access accepted during clearing pass");

	// Each loaded result advances the access clock by exactly one.
	a_clock_step: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (clock_q == $past(clock_q) + STAMP_W'(1)))
		else $error("access clock did not advance with the result");

	// Hit and miss counts change only when a result is loaded.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> (hits_q == $past(hits_q)) && (misses_q == $past(misses_q)))
		else $error("hit or miss count changed without a result");

	// A miss always fills: a miss result always reads memory.
	a_miss_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !hit_q) |=> (reads_q >= $past(reads_q)) && out_valid_q && memory_read)
		else $error("miss result without a memory read");
`endif

endmodule

>>> hw/rtl/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/sacl_way_cmp.sv
// ----------------------------------------------------------------------------
// sacl_way_cmp
// Shared compare unit: matches one way's tag against the access tag and
// measures the way's age against the oldest way seen so far.
// ----------------------------------------------------------------------------
module sacl_way_cmp #(
	parameter int TAG_W = 48
) (
	input  logic [TAG_W-1:0]            key_tag,
	input  logic [TAG_W-1:0]            way_tag,
	input  logic [sacl_pkg::STAMP_W-1:0] now,
	input  logic [sacl_pkg::STAMP_W-1:0] way_stamp,
	input  logic [sacl_pkg::STAMP_W-1:0] best_age,
	input  logic                        have_best,
	output sacl_pkg::cmp_res_t          res
);
	import sacl_pkg::*;

	logic [STAMP_W-1:0] age;

	// Age is taken modulo the stamp width so it stays right across clock wrap.
	assign age = now - way_stamp;

	always_comb begin
		res.match = (key_tag == way_tag);
		res.older = !have_best || (age > best_age);
		res.age   = age;
	end

endmodule

>>> bench/tb_set_assoc_cache_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lookup
// Self-checking bench for the set-associative cache lookup. A directed table
// covers the reset state, address extremes, the clamped and wrapped register
// settings and LRU against FIFO eviction. Random phases follow, each with its
// own register setting, address pool and idling pattern. Every transaction
// on the result channel is compared with a behavioral cache model or, for a pinned row, with its table result.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lookup;
	import sacl_pkg::*;

	localparam int SETS        = 64;
	localparam int WAYS        = 8;
	localparam int ADDR_BITS   = 48;
	localparam int SETTLE      = 24;
	localparam int STUCK_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int NPHASE      = 16;
	localparam int PHASE_ITEMS = 120;
	localparam int POOL_MAX    = 24;
	localparam int NDIR        = 34;

	// Access kinds on the kind port.
	localparam logic ACC_READ  = 1'b0;
	localparam logic ACC_WRITE = 1'b1;

	typedef struct packed {
		logic       hit;
		logic       mem_rd;
		logic       mem_wr;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [31:0] reads;
		logic [31:0] writes;
	} lookup_result_t;

	typedef enum logic [1:0] {ROW_READ, ROW_WRITE, ROW_CFG} row_op_t;

	typedef struct packed {
		row_op_t        op;
		logic [1:0]     reg_sel;
		logic [3:0]     reg_val;
		logic [47:0]    addr;
		logic           pinned;
		lookup_result_t want;
	} dir_row_t;

	// Directed stimulus. Pinned rows carry a result read straight off the
	// reset state; all other rows are checked against the cache model.
	localparam dir_row_t DIRECTED [NDIR] = '{
		// Reset setting: one way, one set, LRU. Fill, hit, evict, hit.
		'{ROW_READ,  '0, 4'd0, 48'h0, 1'b1, '{1'b0, 1'b1, 1'b0, 32'd0, 32'd1, 32'd1, 32'd0}},
		'{ROW_WRITE, '0, 4'd0, 48'h0, 1'b1, '{1'b1, 1'b0, 1'b1, 32'd1, 32'd1, 32'd1, 32'd1}},
		'{ROW_READ,  '0, 4'd0, 48'hFFFF_FFFF_FFFF, 1'b1,
			'{1'b0, 1'b1, 1'b0, 32'd1, 32'd2, 32'd2, 32'd1}},
		'{ROW_WRITE, '0, 4'd0, 48'hFFFF_FFFF_FFFF, 1'b1,
			'{1'b1, 1'b0, 1'b1, 32'd2, 32'd2, 32'd2, 32'd2}},
		// Largest offset, index wider than the set count, zero ways, FIFO.
		'{ROW_CFG, CFG_OFFSET_BITS,    4'd15, 48'h0, 1'b0, '0},
		'{ROW_CFG, CFG_SET_INDEX_BITS, 4'd7,  48'h0, 1'b0, '0},
		'{ROW_CFG, CFG_WAYS_IN_USE,    4'd0,  48'h0, 1'b0, '0},
		'{ROW_CFG, CFG_REPLACE_LRU,    4'd0,  48'h0, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h5555_5555_5555, 1'b0, '0},
		'{ROW_WRITE, '0, 4'd0, 48'hAAAA_AAAA_AAAA, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h5555_5555_5555, 1'b0, '0},
		// Sixty-four sets, more ways than exist, LRU.
		'{ROW_CFG, CFG_OFFSET_BITS,    4'd0,  48'h0, 1'b0, '0},
		'{ROW_CFG, CFG_SET_INDEX_BITS, 4'd6,  48'h0, 1'b0, '0},
		'{ROW_CFG, CFG_WAYS_IN_USE,    4'd15, 48'h0, 1'b0, '0},
		'{ROW_CFG, CFG_REPLACE_LRU,    4'd1,  48'h0, 1'b0, '0},
		// Fill every way of set three, lowest free way first.
		'{ROW_READ,  '0, 4'd0, 48'h003, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h043, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h083, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h0C3, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h103, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h143, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h183, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h1C3, 1'b0, '0},
		// A hit refreshes the first way, so the second is the victim.
		'{ROW_WRITE, '0, 4'd0, 48'h003, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h203, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h043, 1'b0, '0},
		// Under FIFO: 083 was evicted above and misses again, then 243 misses too.
		'{ROW_CFG, CFG_REPLACE_LRU,    4'd0,  48'h0, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h083, 1'b0, '0},
		'{ROW_WRITE, '0, 4'd0, 48'h243, 1'b0, '0},
		// Seven index bits: set 127 folds onto set 63.
		'{ROW_CFG, CFG_SET_INDEX_BITS, 4'd7,  48'h0, 1'b0, '0},
		'{ROW_CFG, CFG_WAYS_IN_USE,    4'd2,  48'h0, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h07F, 1'b0, '0},
		'{ROW_WRITE, '0, 4'd0, 48'h03F, 1'b0, '0},
		'{ROW_READ,  '0, 4'd0, 48'h0BF, 1'b0, '0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  kind;
	logic [FIELD_ADDR_W-1:0] address;
	logic                  out_valid;
	logic                  out_ready;
	logic                  hit;
	logic                  memory_read;
	logic                  memory_write;
	logic [CNT_W-1:0]      hit_count;
	logic [CNT_W-1:0]      miss_count;
	logic [CNT_W-1:0]      memory_read_count;
	logic [CNT_W-1:0]      memory_write_count;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Cache model state and its copy of the registers.
	bit          way_ok    [SETS*WAYS];
	logic [47:0] way_tag   [SETS*WAYS];
	logic [31:0] way_stamp [SETS*WAYS];
	logic [31:0] clock_now   = '0;
	logic [31:0] hits_seen   = '0;
	logic [31:0] misses_seen = '0;
	logic [31:0] reads_seen  = '0;
	logic [31:0] writes_seen = '0;
	logic [3:0]  cfg_offset  = 4'd0;
	logic [2:0]  cfg_sidx    = 3'd0;
	logic [3:0]  cfg_ways    = 4'd1;
	logic        cfg_lru     = 1'b1;

	// Results still owed by the block, oldest first.
	lookup_result_t pending_results [$];

	bit             pin_on         = 1'b0;
	lookup_result_t pin_want       = '0;
	bit             hold_request   = 1'b0;
	int             send_idle_pct  = 0;
	int             recv_stall_pct = 0;
	int             mismatch_count = 0;
	int             stuck_cycles   = 0;

	set_assoc_cache_lookup #(
		.SETS(SETS),
		.WAYS(WAYS),
		.ADDR_BITS(ADDR_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.address(address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.memory_read(memory_read),
		.memory_write(memory_write),
		.hit_count(hit_count),
		.miss_count(miss_count),
		.memory_read_count(memory_read_count),
		.memory_write_count(memory_write_count),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [31:0] sat_bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// One access through the cache model: tag match, victim choice, counts.
	function automatic lookup_result_t predict_lookup(input logic is_wr,
		input logic [47:0] addr);
		logic [47:0]    above;
		logic [47:0]    tag_v;
		int             set_no;
		int             base;
		int             nways;
		int             victim;
		logic [31:0]    best_age;
		logic [31:0]    age;
		logic           hit_f;
		logic           free_f;
		lookup_result_t r;
		above  = addr >> cfg_offset;
		set_no = int'((above & ((48'd1 << cfg_sidx) - 48'd1)) % SETS);
		tag_v  = above >> cfg_sidx;
		nways  = (cfg_ways == 4'd0) ? 1 : ((cfg_ways > WAYS) ? WAYS : int'(cfg_ways));
		base   = set_no * WAYS;
		hit_f  = 1'b0;
		for (int w = 0; w < nways; w++) begin
			if (!hit_f && way_ok[base+w] && way_tag[base+w] == tag_v) begin
				hit_f = 1'b1;
				if (cfg_lru)
					way_stamp[base+w] = clock_now;
			end
		end
		if (!hit_f) begin
			// Lowest free way first, else the oldest stamp.
			free_f = 1'b0;
			victim = 0;
			for (int w = 0; w < nways; w++) begin
				if (!free_f && !way_ok[base+w]) begin
					victim = w;
					free_f = 1'b1;
				end
			end
			if (!free_f) begin
				best_age = clock_now - way_stamp[base];
				for (int w = 1; w < nways; w++) begin
					age = clock_now - way_stamp[base+w];
					if (age > best_age) begin
						best_age = age;
						victim   = w;
					end
				end
			end
			way_ok[base+victim]    = 1'b1;
			way_tag[base+victim]   = tag_v;
			way_stamp[base+victim] = clock_now;
			misses_seen = sat_bump(misses_seen);
			reads_seen  = sat_bump(reads_seen);
		end else begin
			hits_seen = sat_bump(hits_seen);
		end
		if (is_wr)
			writes_seen = sat_bump(writes_seen);
		clock_now = clock_now + 32'd1;
		r.hit    = hit_f;
		r.mem_rd = !hit_f;
		r.mem_wr = is_wr;
		r.hits   = hits_seen;
		r.misses = misses_seen;
		r.reads  = reads_seen;
		r.writes = writes_seen;
		return r;
	endfunction

	function automatic logic [47:0] random_address();
		return {16'($urandom()), 32'($urandom())};
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatch_count++;
		end
	endtask

	// Offer one access, after a random gap, and hold it until it is taken.
	task automatic issue(input logic is_wr, input logic [47:0] a, input bit pinned,
		input lookup_result_t want);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pin_on   = pinned;
		pin_want = want;
		in_valid <= 1'b1;
		kind     <= is_wr;
		address  <= a;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering, wait for every owed result, then let the block settle.
	task automatic quiesce(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		case (sel)
			CFG_OFFSET_BITS:    cfg_offset = val;
			CFG_SET_INDEX_BITS: cfg_sidx   = val[2:0];
			CFG_WAYS_IN_USE:    cfg_ways   = val;
			CFG_REPLACE_LRU:    cfg_lru    = val[0];
			default:            ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Predict on each accepted access, check each accepted result, and
	// watch for a channel that has stopped moving.
	always @(posedge clk) begin : scoreboard
		lookup_result_t want;
		lookup_result_t got;
		logic           moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_valid && out_ready) begin
				moved = 1'b1;
				got = '{hit, memory_read, memory_write, hit_count, miss_count,
					memory_read_count, memory_write_count};
				if (pending_results.size() == 0) begin
					$error("result transaction with no access outstanding");
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("hit", 32'(want.hit), 32'(got.hit));
					check_field("memory_read", 32'(want.mem_rd), 32'(got.mem_rd));
					check_field("memory_write", 32'(want.mem_wr), 32'(got.mem_wr));
					check_field("hit_count", want.hits, got.hits);
					check_field("miss_count", want.misses, got.misses);
					check_field("memory_read_count", want.reads, got.reads);
					check_field("memory_write_count", want.writes, got.writes);
				end
			end
			if (in_valid && in_ready) begin
				moved = 1'b1;
				want = predict_lookup(kind, address);
				pending_results.push_back(pin_on ? pin_want : want);
			end
			stuck_cycles = moved ? 0 : stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("set_assoc_cache_lookup verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [3:0]  off_v;
		logic [2:0]  sidx_v;
		logic [3:0]  ways_v;
		logic        lru_v;
		logic [47:0] pool [POOL_MAX];
		int          pool_n;
		logic [47:0] set_mask;
		logic [47:0] off_mask;
		logic [47:0] addr_v;
		bit          prev_cfg;
		in_valid  = 1'b0;
		kind      = ACC_READ;
		address   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_OFFSET_BITS;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table.
		prev_cfg = 1'b0;
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].op == ROW_CFG) begin
				if (!prev_cfg)
					quiesce(SETTLE);
				write_reg(DIRECTED[i].reg_sel, DIRECTED[i].reg_val);
				prev_cfg = 1'b1;
			end else begin
				issue((DIRECTED[i].op == ROW_WRITE) ? ACC_WRITE : ACC_READ,
					DIRECTED[i].addr, DIRECTED[i].pinned, DIRECTED[i].want);
				prev_cfg = 1'b0;
			end
		end

		// Random phases: the first four use fixed settings, the others random ones.
		for (int ph = 0; ph < NPHASE; ph++) begin
			case (ph)
				0: begin off_v = 4'd0;  sidx_v = 3'd0; ways_v = 4'd8;  lru_v = 1'b1; end
				1: begin off_v = 4'd15; sidx_v = 3'd7; ways_v = 4'd15; lru_v = 1'b0; end
				2: begin off_v = 4'd0;  sidx_v = 3'd6; ways_v = 4'd1;  lru_v = 1'b0; end
				3: begin off_v = 4'd4;  sidx_v = 3'd3; ways_v = 4'd4;  lru_v = 1'b1; end
				default: begin
					off_v  = 4'($urandom_range(15));
					sidx_v = 3'($urandom_range(7));
					ways_v = 4'($urandom_range(15));
					lru_v  = 1'($urandom_range(1));
				end
			endcase
			quiesce(SETTLE);
			write_reg(CFG_OFFSET_BITS, off_v);
			write_reg(CFG_SET_INDEX_BITS, {1'b0, sidx_v});
			write_reg(CFG_WAYS_IN_USE, ways_v);
			write_reg(CFG_REPLACE_LRU, {3'b000, lru_v});

			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase

			// Hot blocks for this phase; about half share one set so
			// that ways fill and get evicted.
			set_mask = ((48'd1 << sidx_v) - 48'd1) << off_v;
			off_mask = (48'd1 << off_v) - 48'd1;
			pool_n   = $urandom_range(POOL_MAX, 2);
			for (int k = 0; k < pool_n; k++) begin
				pool[k] = random_address();
				if (k > 0 && $urandom_range(1))
					pool[k] = (pool[k] & ~set_mask) | (pool[0] & set_mask);
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Long result hold-off while accesses keep coming.
				if (ph == 2 && n == 20)
					hold_request = 1'b1;
				// Sender pause until every result is back.
				if (ph == 5 && n == 60)
					quiesce(0);
				if ($urandom_range(99) < 75)
					addr_v = pool[$urandom_range(pool_n - 1)] ^ (random_address() & off_mask);
				else
					addr_v = random_address();
				issue($urandom_range(1) ? ACC_WRITE : ACC_READ, addr_v, 1'b0, '0);
			end
		end

		quiesce(SETTLE);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("set_assoc_cache_lookup verification clean");
		else
			$display("set_assoc_cache_lookup verification failed");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/sacl_pkg.sv
hw/rtl/sacl_ram.sv
hw/rtl/sacl_way_cmp.sv
hw/rtl/set_assoc_cache_lookup.sv
bench/tb_set_assoc_cache_lookup.sv
